/* rtl/sbp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the six-button pad select-line sequencer.
// No dependencies; every other file imports this package.
package sbp_pkg;

   // Item kinds carried on the request channel.
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Bit of the written byte that carries the select (TH) line.
   localparam int unsigned TH_BIT = 6;

   // Idle counter value that must be exceeded before a pad's phase resets.
   localparam logic [4:0] IDLE_LIMIT = 5'd25;

   // Port value with no line pulled low, and the masks that force bits low.
   localparam logic [6:0] PORT_IDLE = 7'h7F;
   localparam logic [6:0] MASK_LOW  = 7'h33;
   localparam logic [6:0] MASK_ZERO = 7'h30;
   localparam logic [6:0] MASK_ONES = 7'h3F;

   // Per-pad update controls driven by the top level for one transfer.
   typedef struct packed {
      logic write;   // a write addresses this pad
      logic th;      // select level being written
      logic tick;    // timing tick for all pads
      logic six;     // pad is configured as six-button
   } pad_ctrl_type;

endpackage

/* rtl/sbp_pad_cell.sv */
`timescale 1ns / 1ps
// State of one pad: select level, phase counter and idle counter.
// Depends on sbp_pkg.
module sbp_pad_cell
   import sbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pad_ctrl_type ctrl,
   output logic         select_line,
   output logic [1:0]   phase_count
);

   logic       select_ff, select_in;
   logic [1:0] phase_ff, phase_in;
   logic [4:0] idle_ff, idle_in;

   always_comb begin
      select_in = select_ff;
      phase_in  = phase_ff;
      idle_in   = idle_ff;
      if (ctrl.write) begin
         // A rising select edge steps the six-button sequence.
         if (ctrl.six && !select_ff && ctrl.th) begin
            phase_in = phase_ff + 2'd1;
            idle_in  = '0;
         end
         select_in = ctrl.th;
      end else if (ctrl.tick && ctrl.six) begin
         if (idle_ff > IDLE_LIMIT) begin
            phase_in = '0;
            idle_in  = '0;
         end else begin
            idle_in = idle_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff <= 1'b1;
         phase_ff  <= '0;
         idle_ff   <= '0;
      end else begin
         select_ff <= select_in;
         phase_ff  <= phase_in;
         idle_ff   <= idle_in;
      end
   end

   assign select_line = select_ff;
   assign phase_count = phase_ff;

endmodule

/* rtl/sbp_port_fmt.sv */
`timescale 1ns / 1ps
// Forms the seven active-low port bits from select level, phase and buttons.
// Depends on sbp_pkg.
module sbp_port_fmt
   import sbp_pkg::*;
(
   input  logic        select_line,
   input  logic [1:0]  phase_count,
   input  logic        six,
   input  logic [11:0] buttons,
   output logic [6:0]  read_data
);

   logic [2:0] code;
   logic       up, down, left, right, ba, bb, bc, st, bx, by, bz, md;

   assign {md, bz, by, bx, st, bc, bb, ba, right, left, down, up} = buttons;

   // The phase only matters for six-button pads.
   assign code = six ? {phase_count, select_line} : {2'b00, select_line};

   always_comb begin
      unique case (code)
         3'd1, 3'd3, 3'd5:
            read_data = {1'b1, ~bc, ~bb, ~right, ~left, ~down, ~up};
         3'd0, 3'd2:
            read_data = {1'b1, ~st, ~ba, 2'b11, ~down, ~up} & MASK_LOW;
         3'd4:
            read_data = {1'b1, ~st, ~ba, 4'hF} & MASK_ZERO;
         3'd6:
            read_data = {1'b1, ~st, ~ba, 4'hF} & MASK_ONES;
         3'd7:
            read_data = {1'b1, ~bc, ~bb, ~md, ~bx, ~by, ~bz};
      endcase
   end

endmodule

/* rtl/six_button_pad_th_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the multiplexed game pad port sequencer.
// Depends on sbp_pkg, sbp_pad_cell and sbp_port_fmt.
//
//   Channel   Direction   Ports                                         Moves
//   req       in          req_valid, req_stall, req_kind, req_pad_index,
//                         req_write_data, req_buttons                   one item
//   rsp       out         rsp_valid, rsp_stall, rsp_read_data           one result
//   csr       in          csr_wr_en, csr_wr_data                        mask write
//
// Each item is decoded, the pad state is updated and a read's result is
// loaded into the output stage at the same clock edge. A result appears
// on rsp in the cycle after its read transfer when the output register is
// free, and otherwise follows the result ahead of it once that one has been
// taken. Writes and ticks give no result. Reset sets all select lines high
// and clears phases, idle counters and the six-button mask. A second output
// entry lets one more read be taken while a result is stalled; req_stall
// only rises when both entries hold results.
module six_button_pad_th_sequencer
   import sbp_pkg::*;
#(
   parameter int unsigned NUM_PADS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_pad_index,
   input  logic [7:0]  req_write_data,
   input  logic [11:0] req_buttons,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_read_data,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]   six_mask_ff, six_mask_in;
   logic         out_valid_ff, out_valid_in;
   logic [6:0]   out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   logic [6:0]   skid_data_ff, skid_data_in;

   kind_type     kind;
   logic         req_fire, rsp_fire, new_rsp, pad_in_range;
   logic         pad_select, pad_six;
   logic [1:0]   pad_phase;
   logic [6:0]   fmt_data, new_data;

   logic [NUM_PADS-1:0]       select_vec;
   logic [NUM_PADS-1:0][1:0]  phase_vec;
   pad_ctrl_type              ctrl_vec [NUM_PADS];

   assign kind      = kind_type'(req_kind);
   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;

   // Configuration register; user must write it only while idle (not checked).
   assign six_mask_in = csr_wr_en ? csr_wr_data : six_mask_ff;

   assign pad_in_range = 32'(req_pad_index) < NUM_PADS;

   // One state cell per pad; each sees only its own write strobe.
   for (genvar p = 0; p < NUM_PADS; p++) begin : g_pad
      always_comb begin
         ctrl_vec[p].write = req_fire && (kind == KIND_WRITE) && (req_pad_index == 3'(p));
         ctrl_vec[p].th    = req_write_data[TH_BIT];
         ctrl_vec[p].tick  = req_fire && (kind == KIND_TICK);
         ctrl_vec[p].six   = six_mask_ff[p];
      end

      sbp_pad_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl_vec[p]),
         .select_line (select_vec[p]),
         .phase_count (phase_vec[p])
      );
   end

   // Pick the addressed pad's state for a read.
   always_comb begin
      pad_select = 1'b1;
      pad_phase  = '0;
      pad_six    = 1'b0;
      for (int p = 0; p < NUM_PADS; p++) begin
         if (req_pad_index == 3'(p)) begin
            pad_select = select_vec[p];
            pad_phase  = phase_vec[p];
            pad_six    = six_mask_ff[p];
         end
      end
   end

   sbp_port_fmt u_fmt (
      .select_line (pad_select),
      .phase_count (pad_phase),
      .six         (pad_six),
      .buttons     (req_buttons),
      .read_data   (fmt_data)
   );

   assign new_rsp  = req_fire && (kind == KIND_READ);
   assign new_data = pad_in_range ? fmt_data : PORT_IDLE;

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_fire) begin
         out_valid_in = new_rsp;
         out_data_in  = new_data;
      end else if (new_rsp) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         six_mask_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         six_mask_ff   <= six_mask_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

endmodule

/* rtl/sbp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the pad sequencer, attached by the bind below.
// Depends on sbp_pkg and six_button_pad_th_sequencer.
module sbp_checker
   import sbp_pkg::*;
#(
   parameter int unsigned NUM_PADS = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_kind,
   input logic [2:0]  req_pad_index,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_read_data
);

   logic req_fire, read_fire, other_fire;

   assign req_fire   = req_valid && !req_stall;
   assign read_fire  = req_fire && (req_kind == KIND_READ);
   assign other_fire = req_fire && (req_kind != KIND_READ);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

   // A read taken into an empty output shows up on the next cycle.
   a_read_next: assert property (@(posedge clock) disable iff (reset)
      read_fire && !rsp_valid |=> rsp_valid)
      else $error("read result missing");

   // A read of a pad that does not exist returns all lines high.
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      read_fire && !rsp_valid && (32'(req_pad_index) >= NUM_PADS)
      |=> rsp_read_data == PORT_IDLE)
      else $error("out-of-range read gave wrong data");

   // Writes and ticks never produce a result.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      other_fire && !rsp_valid |=> !rsp_valid)
      else $error("result without a read");

   // Input is only held off while a result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

endmodule

bind six_button_pad_th_sequencer sbp_checker #(.NUM_PADS(NUM_PADS)) u_sbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_kind      (req_kind),
   .req_pad_index (req_pad_index),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_data (rsp_read_data)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for six_button_pad_th_sequencer: read, write and tick
// transfers checked against an in-bench model of the pad ports.
// Depends on sbp_pkg and the six_button_pad_th_sequencer RTL.
module testbench;
   import sbp_pkg::*;

   localparam int PADS = 8;

   // One request transfer as the sender sees it. When wait_drain is set the
   // sender holds the item back until every expected read result has arrived.
   typedef struct {
      kind_type    kind;
      logic [2:0]  pad;
      logic [7:0]  data;
      logic [11:0] buttons;
      bit          wait_drain;
   } pad_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kind_type    req_kind = KIND_NONE;
   logic [2:0]  req_pad_index = '0;
   logic [7:0]  req_write_data = '0;
   logic [11:0] req_buttons = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_read_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // Mirror of the block state, updated in transfer order.
   logic [7:0]  six_mask;
   logic        th_level [PADS];
   logic [1:0]  phase [PADS];
   logic [4:0]  idle_cnt [PADS];

   pad_item_type pending_items [$];
   logic [6:0]   expected_reads [$];
   int           error_count = 0;
   int           items_queued = 0;
   // While calm is set neither side idles or stalls.
   bit           calm = 1'b0;

   six_button_pad_th_sequencer #(.NUM_PADS(PADS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_pad_index  (req_pad_index),
      .req_write_data (req_write_data),
      .req_buttons    (req_buttons),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The seven active-low port bits a read of pad p returns with the buttons b.
   // The row is picked by the select line, and on a six-button pad also by
   // the phase: row = TH + 2 * phase.
   function automatic logic [6:0] port_image(logic [2:0] p, logic [11:0] b);
      logic [2:0] row;
      logic [6:0] v;
      row = {2'b00, th_level[p]};
      if (six_mask[p]) row = row + {phase[p], 1'b0};
      case (row)
         3'd1, 3'd3, 3'd5: v = {1'b1, ~b[6], ~b[5], ~b[3], ~b[2], ~b[1], ~b[0]};
         3'd0, 3'd2:       v = {1'b0, ~b[7], ~b[4], 2'b00, ~b[1], ~b[0]};
         3'd4:             v = {1'b0, ~b[7], ~b[4], 4'b0000};
         3'd6:             v = {1'b0, ~b[7], ~b[4], 4'b1111};
         default:          v = {1'b1, ~b[6], ~b[5], ~b[11], ~b[8], ~b[9], ~b[10]};
      endcase
      return v;
   endfunction

   // Apply one accepted transfer to the mirrored state. A read queues the
   // result it must produce.
   task automatic advance_pads(kind_type k, logic [2:0] p, logic [7:0] d,
                               logic [11:0] b);
      int q;
      case (k)
         KIND_READ: expected_reads.push_back(port_image(p, b));
         KIND_WRITE: begin
            // A rising select edge on a six-button pad steps the phase.
            if (six_mask[p] && !th_level[p] && d[TH_BIT]) begin
               phase[p] = phase[p] + 2'd1;
               idle_cnt[p] = '0;
            end
            th_level[p] = d[TH_BIT];
         end
         KIND_TICK: begin
            for (q = 0; q < PADS; q++) begin
               if (six_mask[q]) begin
                  if (idle_cnt[q] > IDLE_LIMIT) begin
                     phase[q] = '0;
                     idle_cnt[q] = '0;
                  end else begin
                     idle_cnt[q] = idle_cnt[q] + 5'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Sender. The transfer that completes at this edge is fed to the model
   // first, so the drain check below already counts its result. A stalled
   // item is held unchanged; otherwise the next item is offered unless the
   // sender idles or must wait for outstanding reads to drain.
   always @(posedge clock) begin
      pad_item_type nxt;
      bit           offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_pads(req_kind, req_pad_index, req_write_data, req_buttons);
         end
         if (!(req_valid && req_stall)) begin
            offer = 1'b0;
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
               if (!pending_items[0].wait_drain || expected_reads.size() == 0) begin
                  offer = 1'b1;
               end
            end
            if (offer) begin
               nxt = pending_items.pop_front();
               req_kind <= nxt.kind;
               req_pad_index <= nxt.pad;
               req_write_data <= nxt.data;
               req_buttons <= nxt.buttons;
            end
            req_valid <= offer;
         end
      end
   end

   // Receiver. Each result transfer is compared with the oldest expected
   // read, and the stall for the next cycle is chosen at random.
   always @(posedge clock) begin
      logic [6:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reads.size() == 0) begin
               $error("read_data: expected nothing, actual %h", rsp_read_data);
               error_count++;
            end else begin
               want = expected_reads.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data: expected %h, actual %h", want, rsp_read_data);
                  error_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
      end
   end

   task automatic queue_item(kind_type k, logic [2:0] p, logic [7:0] d,
                             logic [11:0] b);
      pad_item_type it;
      it.kind = k;
      it.pad = p;
      it.data = d;
      it.buttons = b;
      it.wait_drain = ($urandom_range(0, 39) == 0);
      pending_items.push_back(it);
      if (k != KIND_NONE) items_queued++;
   endtask

   // Write byte with random bits around the requested select level.
   function automatic logic [7:0] th_byte(logic th);
      logic [7:0] d;
      d = 8'($urandom_range(0, 255));
      d[TH_BIT] = th;
      return d;
   endfunction

   // One random stretch of stimulus. Most of it walks a pad through its
   // phases with select toggles and reads in between, since only such
   // sequences reach the extra-button rows. Tick bursts run pads into
   // their timeout, and the rest is loose noise including unused kinds.
   task automatic queue_sequence();
      int          pick;
      int          n;
      int          i;
      logic [2:0]  p;
      pick = $urandom_range(0, 99);
      p = 3'($urandom_range(0, PADS - 1));
      if (pick < 60) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) begin
            queue_item(KIND_WRITE, p, th_byte(1'b0), 12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 2) != 0)
               queue_item(KIND_READ, p, 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            queue_item(KIND_WRITE, p, th_byte(1'b1), 12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 2) != 0)
               queue_item(KIND_READ, p, 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 5) == 0)
               queue_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
         end
      end else if (pick < 75) begin
         n = $urandom_range(1, 30);
         for (i = 0; i < n; i++)
            queue_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                       12'($urandom_range(0, 4095)));
         queue_item(KIND_READ, p, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
         queue_item(KIND_WRITE, p, th_byte(1'b0), 12'($urandom_range(0, 4095)));
         queue_item(KIND_READ, p, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
      end else begin
         queue_item(kind_type'($urandom_range(0, 3)), p, 8'($urandom_range(0, 255)),
                    12'($urandom_range(0, 4095)));
      end
   endtask

   // Wait until the sender is empty and every read result has arrived, then
   // let the last write or tick settle. Missing results count as failures.
   task automatic wait_idle();
      int n;
      n = 0;
      while ((pending_items.size() > 0 || req_valid || expected_reads.size() > 0)
             && n < 4000) begin
         @(posedge clock);
         n++;
      end
      if (expected_reads.size() > 0) begin
         $error("read_data: %0d expected results never arrived", expected_reads.size());
         error_count += expected_reads.size();
         expected_reads.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // The mask is only written while the block is idle, so the model can
   // take the new value at the same edge.
   task automatic write_mask(logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      six_mask = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [7:0] masks [6];
      int         ph;
      int         budget;
      six_mask = '0;
      for (int q = 0; q < PADS; q++) begin
         th_level[q] = 1'b1;
         phase[q] = '0;
         idle_cnt[q] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: pad 0 is six-button and walked through all four phases
      // with reads at both select levels, including the phase wrap; pad 7 is
      // three-button and must ignore its rising edge.
      write_mask(8'h7F);
      @(negedge clock);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd7, 8'hFF, 12'hFFF);
      queue_item(KIND_WRITE, 3'd0, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'hFFF);
      queue_item(KIND_WRITE, 3'd0, 8'h40, 12'h000);
      queue_item(KIND_WRITE, 3'd0, 8'hBF, 12'h000);
      queue_item(KIND_WRITE, 3'd0, 8'hFF, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'hFFF);
      queue_item(KIND_WRITE, 3'd0, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h0B0);
      queue_item(KIND_WRITE, 3'd0, 8'h40, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'hFFF);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h000);
      queue_item(KIND_WRITE, 3'd0, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h000);
      queue_item(KIND_WRITE, 3'd0, 8'h40, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h555);
      queue_item(KIND_WRITE, 3'd7, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd7, 8'h00, 12'hAAA);
      queue_item(KIND_WRITE, 3'd7, 8'h40, 12'h000);
      queue_item(KIND_READ,  3'd7, 8'h00, 12'hFFF);
      queue_item(KIND_NONE,  3'd5, 8'hFF, 12'hFFF);
      queue_item(KIND_TICK,  3'd0, 8'h00, 12'h000);
      queue_item(KIND_READ,  3'd0, 8'h00, 12'h000);
      wait_idle();

      // Random part over several mask settings, the extremes among them.
      // The third setting runs with no idling on either side.
      masks[0] = 8'hFF;
      masks[1] = 8'h00;
      masks[2] = 8'hA5;
      masks[3] = 8'h5A;
      masks[4] = 8'($urandom_range(0, 255));
      masks[5] = 8'hFF;
      for (ph = 0; ph < 6; ph++) begin
         write_mask(masks[ph]);
         calm = (ph == 2);
         @(negedge clock);
         budget = items_queued + 115;
         while (items_queued < budget) queue_sequence();
         wait_idle();
      end
      calm = 1'b0;

      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
